FILE: rtl/core/ordered_timer_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Ordered timer queue: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define ORDERED_TIMER_QUEUE_UNIT_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset
`define OTQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a consequent holds whenever its antecedent does
`define OTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/otq_pkg.sv
// ----------------------------------------------------------------------------
// Ordered timer queue package
// Payload types, request codes and the command set of the timer cells.
// ----------------------------------------------------------------------------
package otq_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_ADD    = 3'd1;
    localparam logic [2:0] REQ_CANCEL = 3'd2;
    localparam logic [2:0] REQ_RESET  = 3'd3;
    localparam logic [2:0] REQ_QUERY  = 3'd4;

    // most expiries reported by one tick
    localparam int unsigned RES_MAX = 16;
    localparam int unsigned CNT_W   = 5;

    // largest reportable distance, one below the empty answer
    localparam logic [47:0] DIST_SAT  = 48'hFFFF_FFFF_FFFE;
    localparam logic [47:0] DIST_NONE = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] ival_ms;
        logic        periodic;
        logic        restart;
        logic [3:0]  slot;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [3:0]  slot_out;
        logic        front_notify;
        logic [47:0] next_interval;
        logic        has_expired;
        logic        last;
    } t_out;

    // operations broadcast to the cells
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_ADD       = 3'd1,
        OP_CANCEL    = 3'd2,
        OP_RESET     = 3'd3,
        OP_EXPIRE    = 3'd4,
        OP_CLR_TAKEN = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     periodic;
        logic     restart;
    } t_cell_cmd;

    // what a scan wave looks for
    typedef enum logic [1:0] {
        SCAN_FREE = 2'd0,
        SCAN_ALL  = 2'd1,
        SCAN_DUE  = 2'd2
    } t_scan_mode;

endpackage

FILE: rtl/core/otq_cell.sv
// ----------------------------------------------------------------------------
// Ordered timer queue: timer cell
// Holds one timer and passes the running scan winner on to the next cell.
// ----------------------------------------------------------------------------
module otq_cell #(
    parameter int TIME_BITS = 48,
    parameter int IW        = 4,
    parameter int IDX       = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  otq_pkg::t_cell_cmd    i_cmd,
    input  logic [IW-1:0]         i_sel,
    input  logic [31:0]           i_ival,
    input  logic [TIME_BITS-1:0]  i_wdl,
    input  logic [TIME_BITS-1:0]  i_now,
    input  otq_pkg::t_scan_mode   i_mode,
    input  logic                  i_tok,
    input  logic                  i_cvalid,
    input  logic [TIME_BITS-1:0]  i_cdl,
    input  logic [IW-1:0]         i_cidx,
    output logic                  o_tok,
    output logic                  o_cvalid,
    output logic [TIME_BITS-1:0]  o_cdl,
    output logic [IW-1:0]         o_cidx,
    output logic                  o_active,
    output logic [31:0]           o_interval,
    output logic [TIME_BITS-1:0]  o_start
);

    logic                 r_active, r_periodic, r_taken;
    logic [31:0]          r_interval;
    logic [TIME_BITS-1:0] r_start, r_deadline;
    logic                 r_tok, r_cvalid;
    logic [TIME_BITS-1:0] r_cdl;
    logic [IW-1:0]        r_cidx;
    logic                 hit, qual, take;
    logic [TIME_BITS-1:0] key;

    assign hit = (i_sel == IW'(IDX));

    // qualify this timer for the current scan
    always_comb begin
        qual = 1'b0;
        key  = r_deadline;
        case (i_mode)
            otq_pkg::SCAN_FREE: begin
                qual = !r_active;
                key  = '0;
            end
            otq_pkg::SCAN_ALL: qual = r_active;
            otq_pkg::SCAN_DUE: qual = r_active && !r_taken && (r_deadline <= i_now);
            default: qual = 1'b0;
        endcase
    end

    // earlier cells win ties, so take own entry only when strictly earlier
    assign take = qual && (!i_cvalid || (key < i_cdl));

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_periodic <= 1'b0;
            r_taken   <= 1'b0;
            r_tok     <= 1'b0;
        end else begin
            r_tok <= i_tok;
            case (i_cmd.op)
                otq_pkg::OP_ADD: begin
                    if (hit) begin
                        r_active   <= 1'b1;
                        r_periodic <= i_cmd.periodic;
                    end
                end
                otq_pkg::OP_CANCEL: begin
                    if (hit) r_active <= 1'b0;
                end
                otq_pkg::OP_EXPIRE: begin
                    if (hit) begin
                        r_taken <= 1'b1;
                        if (!r_periodic) r_active <= 1'b0;
                    end
                end
                otq_pkg::OP_CLR_TAKEN: r_taken <= 1'b0;
                default: ;
            endcase
        end
    end

    // hold timer payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            otq_pkg::OP_ADD: begin
                if (hit) begin
                    r_interval <= i_ival;
                    r_start    <= i_now;
                    r_deadline <= i_wdl;
                end
            end
            otq_pkg::OP_RESET: begin
                if (hit) begin
                    r_interval <= i_ival;
                    if (i_cmd.restart) r_start <= i_now;
                    r_deadline <= i_wdl;
                end
            end
            otq_pkg::OP_EXPIRE: begin
                if (hit && r_periodic) r_deadline <= i_wdl;
            end
            default: ;
        endcase
    end

    // pass the running winner along the chain
    always_ff @(posedge i_clk) begin
        r_cvalid <= i_cvalid || qual;
        r_cdl    <= take ? key : i_cdl;
        r_cidx   <= take ? IW'(IDX) : i_cidx;
    end

    assign o_tok      = r_tok;
    assign o_cvalid   = r_cvalid;
    assign o_cdl      = r_cdl;
    assign o_cidx     = r_cidx;
    assign o_active   = r_active;
    assign o_interval = r_interval;
    assign o_start    = r_start;

endmodule

FILE: rtl/core/ordered_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// Ordered timer queue unit
// Deadline-ordered timer table built as a chain of timer cells with a
// request sequencer that launches scan waves along the chain.
// ----------------------------------------------------------------------------
// Each timer lives in its own cell; a scan wave enters the first cell and
// is registered in each cell in turn. Cancel and unknown requests need no
// scan, query one scan, reset at most one, add two scans (free slot, then
// front), and a tick one scan per expired timer plus one more unless the
// limit is hit (at most 16 reported per tick). The length of the cell chain
// sets how long a scan takes; a finished item waits in the output register
// while the next request is taken.
module ordered_timer_queue_unit #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  otq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output otq_pkg::t_out o_out_data
);

    `include "ordered_timer_queue_unit_assert.svh"

    localparam int IW = $clog2(SLOTS);
    localparam int TB = TIME_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_POST  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        PH_ALLOC = 2'd0,
        PH_FRONT = 2'd1,
        PH_QUERY = 2'd2,
        PH_DUE   = 2'd3
    } t_phase;

    function automatic otq_pkg::t_out make_out(
        input logic ok, input logic [3:0] slot, input logic fr,
        input logic [47:0] nxt, input logic exp, input logic last
    );
        otq_pkg::t_out o;
        o.ok            = ok;
        o.slot_out      = slot;
        o.front_notify  = fr;
        o.next_interval = nxt;
        o.has_expired   = exp;
        o.last          = last;
        return o;
    endfunction

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    otq_pkg::t_in          r_req, n_req;
    otq_pkg::t_scan_mode   r_mode, n_mode;
    logic [TB-1:0]         r_now, n_now;
    logic                  r_latch, n_latch;
    logic                  r_launch, n_launch;
    logic [IW-1:0]         r_sel, n_sel;
    logic [IW-1:0]         r_s, n_s;
    logic                  r_f, n_f;
    logic [TB-1:0]         r_fdl, n_fdl;
    logic [IW-1:0]         r_fidx, n_fidx;
    logic                  r_pend_v, n_pend_v;
    logic [IW-1:0]         r_pend, n_pend;
    logic [otq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                  r_ov, n_ov;
    otq_pkg::t_out         r_out, n_out;

    otq_pkg::t_cell_cmd    c_cmd;
    logic [TB-1:0]         c_wdl, sum_base;
    logic [31:0]           sum_add;
    logic [IW-1:0]         rd_idx;
    logic                  rd_active;
    logic [31:0]           rd_interval;
    logic [TB-1:0]         rd_start;
    logic                  out_free, sl_ok, fr;
    logic [TB-1:0]         diff;
    logic [47:0]           q_dist;

    logic                  w_tok [0:SLOTS];
    logic                  w_cv  [0:SLOTS];
    logic [TB-1:0]         w_cdl [0:SLOTS];
    logic [IW-1:0]         w_cidx[0:SLOTS];
    logic                  w_active  [0:SLOTS-1];
    logic [31:0]           w_interval[0:SLOTS-1];
    logic [TB-1:0]         w_start   [0:SLOTS-1];
    logic [SLOTS:1]        tok_vec;

    // feed the head of the chain
    assign w_tok[0]  = r_launch;
    assign w_cv[0]   = 1'b0;
    assign w_cdl[0]  = '0;
    assign w_cidx[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        otq_cell #(.TIME_BITS(TB), .IW(IW), .IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (c_cmd),
            .i_sel      (rd_idx),
            .i_ival     (r_req.ival_ms),
            .i_wdl      (c_wdl),
            .i_now      (r_now),
            .i_mode     (r_mode),
            .i_tok      (w_tok[g]),
            .i_cvalid   (w_cv[g]),
            .i_cdl      (w_cdl[g]),
            .i_cidx     (w_cidx[g]),
            .o_tok      (w_tok[g+1]),
            .o_cvalid   (w_cv[g+1]),
            .o_cdl      (w_cdl[g+1]),
            .o_cidx     (w_cidx[g+1]),
            .o_active   (w_active[g]),
            .o_interval (w_interval[g]),
            .o_start    (w_start[g])
        );
        assign tok_vec[g+1] = w_tok[g+1];
    end

    // read the addressed timer
    assign rd_idx      = (r_state == S_POST) ? r_fidx : r_sel;
    assign rd_active   = w_active[rd_idx];
    assign rd_interval = w_interval[rd_idx];
    assign rd_start    = w_start[rd_idx];

    // one deadline adder for add, reset and re-arm
    always_comb begin
        sum_base = r_now;
        sum_add  = r_req.ival_ms;
        if (r_state == S_POST && r_phase == PH_DUE) begin
            sum_add = rd_interval;
        end else if (r_state == S_EXEC && !r_req.restart) begin
            sum_base = rd_start;
        end
    end
    assign c_wdl = sum_base + TB'(sum_add);

    assign out_free = !r_ov || i_out_ready;
    assign sl_ok    = (32'(r_req.slot) < SLOTS);
    assign fr       = r_f && (r_fidx == r_s) && !r_latch;

    // distance to the earliest deadline, saturated below the empty code
    assign diff = r_fdl - r_now;
    always_comb begin
        if (r_fdl <= r_now) begin
            q_dist = '0;
        end else if (64'(diff) > 64'(otq_pkg::DIST_SAT)) begin
            q_dist = otq_pkg::DIST_SAT;
        end else begin
            q_dist = 48'(diff);
        end
    end

    // sequence each request through the cell chain
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_req    = r_req;
        n_mode   = r_mode;
        n_now    = r_now;
        n_latch  = r_latch;
        n_launch = 1'b0;
        n_sel    = r_sel;
        n_s      = r_s;
        n_f      = r_f;
        n_fdl    = r_fdl;
        n_fidx   = r_fidx;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;
        c_cmd    = '{op: otq_pkg::OP_NONE, periodic: 1'b0, restart: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_sel   = IW'(i_in_data.slot);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    case (r_req.req_type)
                        otq_pkg::REQ_TICK: begin
                            n_now    = r_now + TB'(1);
                            c_cmd.op = otq_pkg::OP_CLR_TAKEN;
                            n_cnt    = '0;
                            n_pend_v = 1'b0;
                            n_launch = 1'b1;
                            n_mode   = otq_pkg::SCAN_DUE;
                            n_phase  = PH_DUE;
                            n_state  = S_SCAN;
                        end
                        otq_pkg::REQ_ADD: begin
                            n_launch = 1'b1;
                            n_mode   = otq_pkg::SCAN_FREE;
                            n_phase  = PH_ALLOC;
                            n_state  = S_SCAN;
                        end
                        otq_pkg::REQ_CANCEL: begin
                            if (sl_ok && rd_active) c_cmd.op = otq_pkg::OP_CANCEL;
                            n_ov  = 1'b1;
                            n_out = make_out(sl_ok && rd_active, 4'd0, 1'b0, '0,
                                             1'b0, 1'b1);
                        end
                        otq_pkg::REQ_RESET: begin
                            if (!sl_ok) begin
                                n_ov  = 1'b1;
                                n_out = make_out(1'b0, 4'd0, 1'b0, '0, 1'b0, 1'b1);
                            end else if (r_req.ival_ms == rd_interval &&
                                         !r_req.restart) begin
                                n_ov  = 1'b1;
                                n_out = make_out(1'b1, 4'd0, 1'b0, '0, 1'b0, 1'b1);
                            end else if (!rd_active) begin
                                n_ov  = 1'b1;
                                n_out = make_out(1'b0, 4'd0, 1'b0, '0, 1'b0, 1'b1);
                            end else begin
                                c_cmd.op      = otq_pkg::OP_RESET;
                                c_cmd.restart = r_req.restart;
                                n_s      = r_sel;
                                n_launch = 1'b1;
                                n_mode   = otq_pkg::SCAN_ALL;
                                n_phase  = PH_FRONT;
                                n_state  = S_SCAN;
                            end
                        end
                        otq_pkg::REQ_QUERY: begin
                            n_launch = 1'b1;
                            n_mode   = otq_pkg::SCAN_ALL;
                            n_phase  = PH_QUERY;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_ov  = 1'b1;
                            n_out = make_out(1'b0, 4'd0, 1'b0, '0, 1'b0, 1'b1);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // capture the winner as the wave leaves the last cell
                if (w_tok[SLOTS]) begin
                    n_f     = w_cv[SLOTS];
                    n_fdl   = w_cdl[SLOTS];
                    n_fidx  = w_cidx[SLOTS];
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    case (r_phase)
                        PH_ALLOC: begin
                            if (!r_f) begin
                                n_ov  = 1'b1;
                                n_out = make_out(1'b0, 4'd0, 1'b0, '0, 1'b0, 1'b1);
                            end else begin
                                c_cmd.op       = otq_pkg::OP_ADD;
                                c_cmd.periodic = r_req.periodic;
                                n_s      = r_fidx;
                                n_launch = 1'b1;
                                n_mode   = otq_pkg::SCAN_ALL;
                                n_phase  = PH_FRONT;
                                n_state  = S_SCAN;
                            end
                        end
                        PH_FRONT: begin
                            if (fr) n_latch = 1'b1;
                            n_ov  = 1'b1;
                            n_out = make_out(1'b1,
                                (r_req.req_type == otq_pkg::REQ_ADD) ? 4'(r_s) : 4'd0,
                                fr, '0, 1'b0, 1'b1);
                        end
                        PH_QUERY: begin
                            n_ov = 1'b1;
                            if (!r_f) begin
                                n_out = make_out(1'b1, 4'd0, 1'b0, otq_pkg::DIST_NONE,
                                                 1'b0, 1'b1);
                            end else begin
                                n_latch = 1'b0;
                                n_out   = make_out(1'b1, 4'd0, 1'b0, q_dist, 1'b0, 1'b1);
                            end
                        end
                        default: begin
                            if (r_f) begin
                                // report the held expiry, re-arm or drop this one
                                if (r_pend_v) begin
                                    n_ov  = 1'b1;
                                    n_out = make_out(1'b1, 4'(r_pend), 1'b0, '0,
                                                     1'b1, 1'b0);
                                end
                                c_cmd.op = otq_pkg::OP_EXPIRE;
                                n_pend   = r_fidx;
                                n_pend_v = 1'b1;
                                n_cnt    = r_cnt + 1'b1;
                                if (r_cnt + 1'b1 == otq_pkg::CNT_W'(otq_pkg::RES_MAX)) begin
                                    n_state = S_FLUSH;
                                end else begin
                                    n_launch = 1'b1;
                                    n_mode   = otq_pkg::SCAN_DUE;
                                    n_state  = S_SCAN;
                                end
                            end else begin
                                n_ov     = 1'b1;
                                n_pend_v = 1'b0;
                                if (r_pend_v) begin
                                    n_out = make_out(1'b1, 4'(r_pend), 1'b0, '0,
                                                     1'b1, 1'b1);
                                end else begin
                                    n_out = make_out(1'b1, 4'd0, 1'b0, '0, 1'b0, 1'b1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_out    = make_out(1'b1, 4'(r_pend), 1'b0, '0, 1'b1, 1'b1);
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_latch  <= 1'b0;
            r_launch <= 1'b0;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_latch  <= n_latch;
            r_launch <= n_launch;
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
            r_ov     <= n_ov;
        end
    end

    // hold request and scan payload
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_req   <= n_req;
        r_mode  <= n_mode;
        r_sel   <= n_sel;
        r_s     <= n_s;
        r_f     <= n_f;
        r_fdl   <= n_fdl;
        r_fidx  <= n_fidx;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // checks
    `OTQ_ASSERT_ALWAYS(a_one_scan_wave, $onehot0({r_launch, tok_vec}), "two scan waves")
    `OTQ_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= otq_pkg::CNT_W'(otq_pkg::RES_MAX), "count overrun")
    `OTQ_ASSERT_IMP(a_flush_pending, r_state == S_FLUSH, r_pend_v, "flush without held expiry")

endmodule
